// ===== rtl/tstm_pkg.sv =====
// Shared types and constants of the three-stream timestamp matcher.
// No dependencies; the other files but tstm_ram take names from here by scope.
package tstm_pkg;

  localparam int SENSOR_COUNT     = 3;
  localparam int BUFFER_DEPTH_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam int STAMP_W   = 32;
  localparam int TAG_W     = 16;
  localparam int CFG_W     = 16;
  localparam int SENSOR_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRY_W   = STAMP_W + TAG_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 2'd1;

  localparam logic [CFG_W-1:0] MATCH_WINDOW_RST = 16'd50;
  localparam logic [CFG_W-1:0] MAX_AGE_RST      = 16'd100;

  // kind field codes
  localparam logic KIND_ARRIVAL = 1'b0;

  typedef logic [SENSOR_W-1:0] sensor_t;

  typedef enum logic {
    OP_ARRIVE,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e                op;
    sensor_t            sensor;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] now;
  } cmd_t;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic [CFG_W-1:0] match_window;
    logic [CFG_W-1:0] max_age;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    logic               matched;
    logic [TAG_W-1:0]   tag_first;
    logic [TAG_W-1:0]   tag_second;
    logic [TAG_W-1:0]   tag_third;
    logic [STAMP_W-1:0] triple_stamp;
    logic               overflow_drop;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_APPEND,
    ST_LOAD0,
    ST_LATCH0,
    ST_SCAN2,
    ST_SCAN1,
    ST_DONE
  } state_e;

  typedef enum logic {
    WALK_SHIFT,
    WALK_PURGE
  } walk_e;

endpackage

// ===== rtl/tstm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tstm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tstm_front.sv =====
// Front end: classifies incoming requests and holds them in a short queue.
// Depends on tstm_pkg.
module tstm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  tstm_pkg::sensor_t           sensor_i,
  input  logic [tstm_pkg::STAMP_W-1:0] stamp_ms_i,
  input  logic [tstm_pkg::TAG_W-1:0]   frame_tag_i,
  input  logic [tstm_pkg::STAMP_W-1:0] now_ms_i,
  input  logic                        pop_i,
  output tstm_pkg::q_head_t           head_o
);

  localparam int QD  = tstm_pkg::QUEUE_DEPTH;
  localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int NW  = $clog2(QD + 1);
  localparam logic [PW-1:0] LAST = PW'(QD - 1);

  tstm_pkg::cmd_t cmd_in;
  tstm_pkg::cmd_t slot_q [QD];
  logic [PW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [NW-1:0]  fill_q, fill_d;
  logic           push;

  // classify: out-of-range sensors act as a time tick
  always_comb begin
    if (kind_i == tstm_pkg::KIND_ARRIVAL &&
        sensor_i < tstm_pkg::SENSOR_W'(tstm_pkg::SENSOR_COUNT)) begin
      cmd_in.op     = tstm_pkg::OP_ARRIVE;
      cmd_in.sensor = sensor_i;
    end else begin
      cmd_in.op     = tstm_pkg::OP_TICK;
      cmd_in.sensor = '0;
    end
    cmd_in.stamp = stamp_ms_i;
    cmd_in.tag   = frame_tag_i;
    cmd_in.now   = now_ms_i;
  end

  assign in_ready_o = (fill_q != NW'(QD));
  assign push       = in_valid_i && in_ready_o;

  // advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + PW'(1);
    end
    if (push && !pop_i) begin
      fill_d = fill_q + NW'(1);
    end else if (!push && pop_i) begin
      fill_d = fill_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

  assign head_o.valid = (fill_q != '0);
  assign head_o.cmd   = slot_q[rptr_q];

endmodule

// ===== rtl/tstm_back.sv =====
// Back end: sequencer over the entry RAM for shift, append, search and purge,
// plus the result register. Depends on tstm_pkg and tstm_ram.
module tstm_back #(
  parameter int BUFFER_DEPTH = tstm_pkg::BUFFER_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tstm_pkg::cfg_t    cfg_i,
  input  tstm_pkg::q_head_t head_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output tstm_pkg::res_t    res_o
);

  localparam int CW    = $clog2(BUFFER_DEPTH + 1);
  localparam int SLOTS = tstm_pkg::SENSOR_COUNT * BUFFER_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int SW    = tstm_pkg::STAMP_W;
  localparam int TW    = tstm_pkg::TAG_W;
  localparam logic [CW-1:0] FULL = CW'(BUFFER_DEPTH);

  // first slot of a sensor's region
  function automatic logic [AW-1:0] base_of(input tstm_pkg::sensor_t s);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(BUFFER_DEPTH);
      default: b = AW'(2 * BUFFER_DEPTH);
    endcase
    return b;
  endfunction

  tstm_pkg::state_e  state_q, state_d;
  tstm_pkg::cmd_t    cmd_q, cmd_d;
  tstm_pkg::walk_e   walk_mode_q, walk_mode_d;
  tstm_pkg::sensor_t walk_s_q, walk_s_d, sel_s;
  logic [CW-1:0]     cnt_q [tstm_pkg::SENSOR_COUNT];
  logic [CW-1:0]     cnt_d [tstm_pkg::SENSOR_COUNT];
  logic [CW-1:0]     rp_q, rp_d, wp_q, wp_d, pidx_q, pidx_d, i_q, i_d;
  logic [CW-1:0]     idx1_q, idx1_d, idx2_q, idx2_d, n_sel, fidx, drop_idx;
  logic              pvld_q, pvld_d, found_q, found_d, ovf_q, ovf_d;
  logic [SW-1:0]     s0_stamp_q, s0_stamp_d;
  logic [TW-1:0]     s0_tag_q, s0_tag_d, tag1_q, tag1_d, tag2_q, tag2_d;
  tstm_pkg::res_t    res_q, res_d;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [tstm_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0]                rd_stamp, diff_a, diff_b, age, win32, age32;
  logic [TW-1:0]                rd_tag;
  logic                         in_window, too_old, drop_en, drop_it, hit;

  tstm_ram #(
    .WIDTH (tstm_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_stamp = ram_rdata[tstm_pkg::ENTRY_W-1:TW];
  assign rd_tag   = ram_rdata[TW-1:0];

  // window test: either wrap-around difference fits the window
  assign win32     = SW'(cfg_i.match_window);
  assign diff_a    = s0_stamp_q - rd_stamp;
  assign diff_b    = rd_stamp - s0_stamp_q;
  assign in_window = (diff_a <= win32) || (diff_b <= win32);

  // age test: a negative age keeps the entry
  assign age32   = SW'(cfg_i.max_age);
  assign age     = cmd_q.now - rd_stamp;
  assign too_old = !age[SW-1] && (age > age32);

  // pick the buffer whose fill the current state works on
  always_comb begin
    case (state_q)
      tstm_pkg::ST_IDLE:   sel_s = head_i.cmd.sensor;
      tstm_pkg::ST_WALK:   sel_s = walk_s_q;
      tstm_pkg::ST_APPEND: sel_s = cmd_q.sensor;
      tstm_pkg::ST_SCAN2:  sel_s = 2'd2;
      tstm_pkg::ST_SCAN1:  sel_s = 2'd1;
      default:             sel_s = 2'd0;
    endcase
    case (sel_s)
      2'd0:    n_sel = cnt_q[0];
      2'd1:    n_sel = cnt_q[1];
      default: n_sel = cnt_q[2];
    endcase
  end

  // entry dropped by the walk: oldest on overflow; matched one or any too old on purge
  always_comb begin
    case (walk_s_q)
      2'd0:    fidx = i_q;
      2'd1:    fidx = idx1_q;
      default: fidx = idx2_q;
    endcase
    if (walk_mode_q == tstm_pkg::WALK_SHIFT) begin
      drop_en  = 1'b1;
      drop_idx = '0;
    end else begin
      drop_en  = found_q;
      drop_idx = fidx;
    end
    drop_it = (drop_en && pidx_q == drop_idx) ||
              (walk_mode_q == tstm_pkg::WALK_PURGE && too_old);
  end

  assign hit = pvld_q && in_window;

  // sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    walk_mode_d = walk_mode_q;
    walk_s_d    = walk_s_q;
    cnt_d       = cnt_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    pidx_d      = pidx_q;
    pvld_d      = pvld_q;
    i_d         = i_q;
    idx1_d      = idx1_q;
    idx2_d      = idx2_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    s0_stamp_d  = s0_stamp_q;
    s0_tag_d    = s0_tag_q;
    tag1_d      = tag1_q;
    tag2_d      = tag2_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    res_d       = res_q;

    // drain the result register
    if (res_q.valid && out_ready_i) begin
      res_d.valid = 1'b0;
    end

    unique case (state_q)
      tstm_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          cmd_d   = head_i.cmd;
          ovf_d   = 1'b0;
          found_d = 1'b0;
          rp_d    = '0;
          wp_d    = '0;
          pvld_d  = 1'b0;
          if (head_i.cmd.op == tstm_pkg::OP_ARRIVE) begin
            if (n_sel == FULL) begin
              ovf_d       = 1'b1;
              walk_s_d    = head_i.cmd.sensor;
              walk_mode_d = tstm_pkg::WALK_SHIFT;
              state_d     = tstm_pkg::ST_WALK;
            end else begin
              state_d = tstm_pkg::ST_APPEND;
            end
          end else begin
            walk_s_d    = 2'd0;
            walk_mode_d = tstm_pkg::WALK_PURGE;
            state_d     = tstm_pkg::ST_WALK;
          end
        end
      end

      tstm_pkg::ST_WALK: begin
        // compact: write back kept entries at the write pointer, behind the read pointer
        if (pvld_q && !drop_it) begin
          ram_we    = 1'b1;
          ram_waddr = base_of(walk_s_q) + AW'(wp_q);
          wp_d      = wp_q + CW'(1);
        end
        if (rp_q != n_sel) begin
          ram_raddr = base_of(walk_s_q) + AW'(rp_q);
          pidx_d    = rp_q;
          rp_d      = rp_q + CW'(1);
          pvld_d    = 1'b1;
        end else begin
          pvld_d = 1'b0;
        end
        if (rp_q == n_sel && !pvld_q) begin
          cnt_d[walk_s_q] = wp_q;
          rp_d            = '0;
          wp_d            = '0;
          if (walk_mode_q == tstm_pkg::WALK_SHIFT) begin
            state_d = tstm_pkg::ST_APPEND;
          end else if (walk_s_q == 2'd2) begin
            state_d = tstm_pkg::ST_DONE;
          end else begin
            walk_s_d = walk_s_q + 2'd1;
          end
        end
      end

      tstm_pkg::ST_APPEND: begin
        ram_we              = 1'b1;
        ram_waddr           = base_of(cmd_q.sensor) + AW'(n_sel);
        ram_wdata           = {cmd_q.stamp, cmd_q.tag};
        cnt_d[cmd_q.sensor] = n_sel + CW'(1);
        i_d                 = '0;
        state_d             = tstm_pkg::ST_LOAD0;
      end

      tstm_pkg::ST_LOAD0: begin
        if (i_q == n_sel) begin
          // no triple: purge all buffers
          found_d     = 1'b0;
          walk_s_d    = 2'd0;
          walk_mode_d = tstm_pkg::WALK_PURGE;
          rp_d        = '0;
          wp_d        = '0;
          pvld_d      = 1'b0;
          state_d     = tstm_pkg::ST_WALK;
        end else begin
          ram_raddr = base_of(2'd0) + AW'(i_q);
          state_d   = tstm_pkg::ST_LATCH0;
        end
      end

      tstm_pkg::ST_LATCH0: begin
        s0_stamp_d = rd_stamp;
        s0_tag_d   = rd_tag;
        rp_d       = '0;
        pvld_d     = 1'b0;
        state_d    = tstm_pkg::ST_SCAN2;
      end

      tstm_pkg::ST_SCAN2: begin
        if (hit) begin
          idx2_d  = pidx_q;
          tag2_d  = rd_tag;
          rp_d    = '0;
          pvld_d  = 1'b0;
          state_d = tstm_pkg::ST_SCAN1;
        end else if (rp_q == n_sel) begin
          i_d     = i_q + CW'(1);
          state_d = tstm_pkg::ST_LOAD0;
        end else begin
          ram_raddr = base_of(2'd2) + AW'(rp_q);
          pidx_d    = rp_q;
          rp_d      = rp_q + CW'(1);
          pvld_d    = 1'b1;
        end
      end

      tstm_pkg::ST_SCAN1: begin
        if (hit) begin
          idx1_d      = pidx_q;
          tag1_d      = rd_tag;
          found_d     = 1'b1;
          walk_s_d    = 2'd0;
          walk_mode_d = tstm_pkg::WALK_PURGE;
          rp_d        = '0;
          wp_d        = '0;
          pvld_d      = 1'b0;
          state_d     = tstm_pkg::ST_WALK;
        end else if (rp_q == n_sel) begin
          i_d     = i_q + CW'(1);
          state_d = tstm_pkg::ST_LOAD0;
        end else begin
          ram_raddr = base_of(2'd1) + AW'(rp_q);
          pidx_d    = rp_q;
          rp_d      = rp_q + CW'(1);
          pvld_d    = 1'b1;
        end
      end

      tstm_pkg::ST_DONE: begin
        // hold until the result register is free
        if (!res_q.valid || out_ready_i) begin
          res_d.valid         = 1'b1;
          res_d.matched       = found_q;
          res_d.tag_first     = found_q ? s0_tag_q : '0;
          res_d.tag_second    = found_q ? tag1_q : '0;
          res_d.tag_third     = found_q ? tag2_q : '0;
          res_d.triple_stamp  = found_q ? s0_stamp_q : '0;
          res_d.overflow_drop = ovf_q;
          state_d             = tstm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tstm_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tstm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '{default: '0};
      res_q       <= '0;
      pvld_q      <= 1'b0;
      rp_q        <= '0;
      wp_q        <= '0;
      i_q         <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      walk_s_q    <= '0;
      walk_mode_q <= tstm_pkg::WALK_PURGE;
    end else begin
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      pvld_q      <= pvld_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      i_q         <= i_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      walk_s_q    <= walk_s_d;
      walk_mode_q <= walk_mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pidx_q     <= pidx_d;
    idx1_q     <= idx1_d;
    idx2_q     <= idx2_d;
    s0_stamp_q <= s0_stamp_d;
    s0_tag_q   <= s0_tag_d;
    tag1_q     <= tag1_d;
    tag2_q     <= tag2_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/three_stream_timestamp_matcher.sv =====
// Top level of the three-stream timestamp matcher: configuration registers,
// front end queue and back end sequencer. Depends on tstm_pkg, tstm_front, tstm_back.
//
//   channel  handshake              payload
//   in       in_valid_i/in_ready_o  kind_i sensor_i stamp_ms_i frame_tag_i now_ms_i
//   out      out_valid_o/out_ready_i matched_o tag_*_o triple_stamp_ms_o overflow_drop_o
//   cfg      cfg_we_i               cfg_idx_i cfg_wdata_i
//
// One request at a time runs on the back end; all work goes through the single
// read port of the entry RAM. A tick walks all three buffers to purge them; an
// arrival first shifts out the oldest entry when its buffer is full, then runs
// the append, the triple search and the purge walk. Reset empties the buffers
// at once by clearing the fill counts. A two-entry request queue and the result
// register let either side stall; the back end waits only to hand over a result.
module three_stream_timestamp_matcher #(
  parameter int BUFFER_DEPTH = tstm_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [tstm_pkg::SENSOR_W-1:0] sensor_i,
  input  logic [tstm_pkg::STAMP_W-1:0]  stamp_ms_i,
  input  logic [tstm_pkg::TAG_W-1:0]    frame_tag_i,
  input  logic [tstm_pkg::STAMP_W-1:0]  now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          matched_o,
  output logic [tstm_pkg::TAG_W-1:0]    tag_first_o,
  output logic [tstm_pkg::TAG_W-1:0]    tag_second_o,
  output logic [tstm_pkg::TAG_W-1:0]    tag_third_o,
  output logic [tstm_pkg::STAMP_W-1:0]  triple_stamp_ms_o,
  output logic                          overflow_drop_o,
  input  logic                          cfg_we_i,
  input  logic [tstm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tstm_pkg::CFG_W-1:0]    cfg_wdata_i
);

  tstm_pkg::cfg_t    cfg_q;
  tstm_pkg::q_head_t head;
  tstm_pkg::res_t    res;
  logic              pop;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_window <= tstm_pkg::MATCH_WINDOW_RST;
      cfg_q.max_age      <= tstm_pkg::MAX_AGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tstm_pkg::CFG_MATCH_WINDOW: cfg_q.match_window <= cfg_wdata_i;
        tstm_pkg::CFG_MAX_AGE:      cfg_q.max_age      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tstm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .sensor_i    (sensor_i),
    .stamp_ms_i  (stamp_ms_i),
    .frame_tag_i (frame_tag_i),
    .now_ms_i    (now_ms_i),
    .pop_i       (pop),
    .head_o      (head)
  );

  tstm_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_valid_o       = res.valid;
  assign matched_o         = res.matched;
  assign tag_first_o       = res.tag_first;
  assign tag_second_o      = res.tag_second;
  assign tag_third_o       = res.tag_third;
  assign triple_stamp_ms_o = res.triple_stamp;
  assign overflow_drop_o   = res.overflow_drop;

endmodule

// ===== rtl/tstm_checker.sv =====
// Port-level checks of the timestamp matcher result channel, bound to the top.
// Depends on tstm_pkg and three_stream_timestamp_matcher.
module tstm_port_props (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         matched_o,
  input logic [tstm_pkg::TAG_W-1:0]   tag_first_o,
  input logic [tstm_pkg::TAG_W-1:0]   tag_second_o,
  input logic [tstm_pkg::TAG_W-1:0]   tag_third_o,
  input logic [tstm_pkg::STAMP_W-1:0] triple_stamp_ms_o,
  input logic                         overflow_drop_o
);

  // stalled result keeps its valid
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable({matched_o, tag_first_o, tag_second_o, tag_third_o,
               triple_stamp_ms_o, overflow_drop_o}))
    else $error("result payload changed while stalled");

  // a result without a triple carries zero tags and stamp
  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |->
      tag_first_o == '0 && tag_second_o == '0 && tag_third_o == '0 &&
      triple_stamp_ms_o == '0)
    else $error("unmatched result with nonzero fields");

  // no result shows during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind three_stream_timestamp_matcher tstm_port_props u_port_props (.*);

// ===== verif/tstm_checker.sv =====
// Scoreboard of the three-stream timestamp matcher: watches the request, result
// and register ports, predicts every result and compares it field by field.
// Depends on tstm_pkg only.
module tstm_checker
  import tstm_pkg::*;
#(
  parameter int DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 kind_i,
  input  sensor_t              sensor_i,
  input  logic [STAMP_W-1:0]   stamp_ms_i,
  input  logic [TAG_W-1:0]     frame_tag_i,
  input  logic [STAMP_W-1:0]   now_ms_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 matched_i,
  input  logic [TAG_W-1:0]     tag_first_i,
  input  logic [TAG_W-1:0]     tag_second_i,
  input  logic [TAG_W-1:0]     tag_third_i,
  input  logic [STAMP_W-1:0]   triple_stamp_ms_i,
  input  logic                 overflow_drop_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          result_count_o,
  output int unsigned          match_count_o,
  output int unsigned          drop_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               matched;
    logic [TAG_W-1:0]   tag_first;
    logic [TAG_W-1:0]   tag_second;
    logic [TAG_W-1:0]   tag_third;
    logic [STAMP_W-1:0] triple_stamp;
    logic               overflow_drop;
  } triple_result_t;

  // predicted buffer contents, oldest entry first
  logic [STAMP_W-1:0] slot_stamp [SENSOR_COUNT][DEPTH];
  logic [TAG_W-1:0]   slot_tag   [SENSOR_COUNT][DEPTH];
  int unsigned        slot_fill  [SENSOR_COUNT];
  logic [CFG_W-1:0]   window_ms;
  logic [CFG_W-1:0]   age_limit_ms;

  triple_result_t     expected_q [$];
  int unsigned        bad_results = 0;

  // magnitude of the signed 32-bit difference a - b
  function automatic logic [STAMP_W-1:0] stamp_gap(logic [STAMP_W-1:0] a,
                                                   logic [STAMP_W-1:0] b);
    logic [STAMP_W-1:0] d;
    d = a - b;
    if (d[STAMP_W-1]) begin
      d = ~d + 1'b1;
    end
    return d;
  endfunction

  // close the gap left by entry k of sensor s
  function automatic void remove_slot(int s, int k);
    for (int i = k; i + 1 < slot_fill[s]; i++) begin
      slot_stamp[s][i] = slot_stamp[s][i+1];
      slot_tag[s][i]   = slot_tag[s][i+1];
    end
    slot_fill[s]--;
  endfunction

  // drop entries older than the age limit; a stamp ahead of now stays
  function automatic void purge_old(logic [STAMP_W-1:0] now_val);
    int unsigned        keep;
    logic [STAMP_W-1:0] age;
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      keep = 0;
      for (int i = 0; i < slot_fill[s]; i++) begin
        age = now_val - slot_stamp[s][i];
        if (age[STAMP_W-1] || age <= STAMP_W'(age_limit_ms)) begin
          slot_stamp[s][keep] = slot_stamp[s][i];
          slot_tag[s][keep]   = slot_tag[s][i];
          keep++;
        end
      end
      slot_fill[s] = keep;
    end
  endfunction

  // advance the buffers by one request and return the result it causes
  function automatic triple_result_t predict_triple(logic kind, sensor_t sensor,
                                                    logic [STAMP_W-1:0] stamp_val,
                                                    logic [TAG_W-1:0] tag_val,
                                                    logic [STAMP_W-1:0] now_val);
    triple_result_t     r;
    logic [STAMP_W-1:0] s0;
    bit                 found;
    int unsigned        fi, fj, fk;
    r     = '0;
    found = 1'b0;
    fi    = 0;
    fj    = 0;
    fk    = 0;
    if (kind == KIND_ARRIVAL && sensor < SENSOR_COUNT) begin
      if (slot_fill[sensor] >= DEPTH) begin
        remove_slot(sensor, 0);
        r.overflow_drop = 1'b1;
      end
      slot_stamp[sensor][slot_fill[sensor]] = stamp_val;
      slot_tag[sensor][slot_fill[sensor]]   = tag_val;
      slot_fill[sensor]++;

      // first triple in buffer order, sensor 0 outermost
      for (int i = 0; i < slot_fill[0] && !found; i++) begin
        s0 = slot_stamp[0][i];
        for (int j = 0; j < slot_fill[1] && !found; j++) begin
          if (stamp_gap(s0, slot_stamp[1][j]) <= STAMP_W'(window_ms)) begin
            for (int k = 0; k < slot_fill[2] && !found; k++) begin
              if (stamp_gap(s0, slot_stamp[2][k]) <= STAMP_W'(window_ms)) begin
                found = 1'b1;
                fi    = i;
                fj    = j;
                fk    = k;
              end
            end
          end
        end
      end

      if (found) begin
        r.matched      = 1'b1;
        r.tag_first    = slot_tag[0][fi];
        r.tag_second   = slot_tag[1][fj];
        r.tag_third    = slot_tag[2][fk];
        r.triple_stamp = slot_stamp[0][fi];
        remove_slot(2, fk);
        remove_slot(1, fj);
        remove_slot(0, fi);
      end
    end
    purge_old(now_val);
    return r;
  endfunction

  function automatic string show_result(triple_result_t r);
    return $sformatf("matched=%0d tags=%h/%h/%h stamp=%h drop=%0d", r.matched,
                     r.tag_first, r.tag_second, r.tag_third, r.triple_stamp,
                     r.overflow_drop);
  endfunction

  // compare the result on the port with the oldest prediction
  task automatic check_result();
    triple_result_t got_r;
    triple_result_t exp_r;
    string          wrong;
    got_r = {matched_i, tag_first_i, tag_second_i, tag_third_i, triple_stamp_ms_i,
             overflow_drop_i};
    wrong = "";
    result_count_o++;
    if (expected_q.size() == 0) begin
      bad_results++;
      if (bad_results <= 10) begin
        $display("[%0t] result %0d with no request pending: %s", $time,
                 result_count_o, show_result(got_r));
      end
    end else begin
      exp_r = expected_q.pop_front();
      if (got_r.matched !== exp_r.matched) wrong = {wrong, " matched"};
      if (got_r.tag_first !== exp_r.tag_first) wrong = {wrong, " tag_first"};
      if (got_r.tag_second !== exp_r.tag_second) wrong = {wrong, " tag_second"};
      if (got_r.tag_third !== exp_r.tag_third) wrong = {wrong, " tag_third"};
      if (got_r.triple_stamp !== exp_r.triple_stamp) wrong = {wrong, " triple_stamp"};
      if (got_r.overflow_drop !== exp_r.overflow_drop) wrong = {wrong, " overflow_drop"};
      if (wrong != "") begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("[%0t] result %0d wrong in%s", $time, result_count_o, wrong);
          $display("    expected %s", show_result(exp_r));
          $display("    actual   %s", show_result(got_r));
        end
      end
      if (exp_r.matched) match_count_o++;
      if (exp_r.overflow_drop) drop_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_ms      = MATCH_WINDOW_RST;
      age_limit_ms   = MAX_AGE_RST;
      result_count_o = 0;
      match_count_o  = 0;
      drop_count_o   = 0;
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        slot_fill[s] = 0;
      end
      expected_q.delete();
    end else begin
      // compare first: a result never leaves in the cycle its request enters
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        expected_q.insert(expected_q.size(),
                          predict_triple(kind_i, sensor_i, stamp_ms_i, frame_tag_i,
                                         now_ms_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MATCH_WINDOW: window_ms = cfg_wdata_i;
          CFG_MAX_AGE:      age_limit_ms = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o    = expected_q.size();
    fail_count_o = bad_results;
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top of the three-stream timestamp matcher: clock, reset, request and
// register stimulus, receiver stalls and the verdict.
// Depends on tstm_pkg, the matcher RTL and tstm_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tstm_pkg::*;

  localparam int DEPTH       = BUFFER_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 300;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic                 kind      = 1'b0;
  sensor_t              sensor    = '0;
  logic [STAMP_W-1:0]   stamp_ms  = '0;
  logic [TAG_W-1:0]     frame_tag = '0;
  logic [STAMP_W-1:0]   now_ms    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 matched;
  logic [TAG_W-1:0]     tag_first;
  logic [TAG_W-1:0]     tag_second;
  logic [TAG_W-1:0]     tag_third;
  logic [STAMP_W-1:0]   triple_stamp_ms;
  logic                 overflow_drop;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_MATCH_WINDOW;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned match_count;
  int unsigned drop_count;

  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_idle_pct  = 0;
  bit                 hold_req       = 1'b0;
  logic [STAMP_W-1:0] clock_ms       = '0;
  int unsigned        cur_window     = 32'(MATCH_WINDOW_RST);
  int unsigned        cur_age        = 32'(MAX_AGE_RST);
  int unsigned        requests_sent  = 0;
  int unsigned        settings_used  = 1;
  int unsigned        stall_cycles   = 0;

  always #5 clk = ~clk;

  three_stream_timestamp_matcher #(
    .BUFFER_DEPTH(DEPTH)
  ) u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .sensor_i         (sensor),
    .stamp_ms_i       (stamp_ms),
    .frame_tag_i      (frame_tag),
    .now_ms_i         (now_ms),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .matched_o        (matched),
    .tag_first_o      (tag_first),
    .tag_second_o     (tag_second),
    .tag_third_o      (tag_third),
    .triple_stamp_ms_o(triple_stamp_ms),
    .overflow_drop_o  (overflow_drop),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  tstm_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .kind_i           (kind),
    .sensor_i         (sensor),
    .stamp_ms_i       (stamp_ms),
    .frame_tag_i      (frame_tag),
    .now_ms_i         (now_ms),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .matched_i        (matched),
    .tag_first_i      (tag_first),
    .tag_second_i     (tag_second),
    .tag_third_i      (tag_third),
    .triple_stamp_ms_i(triple_stamp_ms),
    .overflow_drop_i  (overflow_drop),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .result_count_o   (result_count),
    .match_count_o    (match_count),
    .drop_count_o     (drop_count)
  );

  // offer one request after a random gap and hold it until it is taken
  task automatic send_req(input op_e op, input sensor_t sensor_val,
                          input logic [STAMP_W-1:0] stamp_val,
                          input logic [TAG_W-1:0] tag_val,
                          input logic [STAMP_W-1:0] now_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = op;
    sensor    = sensor_val;
    stamp_ms  = stamp_val;
    frame_tag = tag_val;
    now_ms    = now_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every predicted result is back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_limits(input logic [CFG_W-1:0] window_val,
                            input logic [CFG_W-1:0] age_val);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_MATCH_WINDOW;
    cfg_wdata = window_val;
    @(negedge clk);
    cfg_idx   = CFG_MAX_AGE;
    cfg_wdata = age_val;
    @(negedge clk);
    cfg_we     = 1'b0;
    cur_window = 32'(window_val);
    cur_age    = 32'(age_val);
    settings_used++;
  endtask

  // corner cases under the reset limits: window 50, age 100
  task automatic directed_checks();
    // exact window edge on both sides, stamp ahead of now
    send_req(OP_ARRIVE, sensor_t'(0), 32'd1000, 16'h0000, 32'd1000);
    send_req(OP_ARRIVE, sensor_t'(1), 32'd1050, 16'hFFFF, 32'd1000);
    send_req(OP_ARRIVE, sensor_t'(2), 32'd950, 16'h1234, 32'd1050);
    // fill sensor 1 past its depth so the oldest entry drops
    for (int i = 0; i <= DEPTH; i++) begin
      send_req(OP_ARRIVE, sensor_t'(1), 32'd5000 + STAMP_W'(i), 16'h0100 + TAG_W'(i),
               32'd5000);
    end
    // out-of-range sensor acts as a tick
    send_req(OP_ARRIVE, sensor_t'(3), 32'hFFFF_FFFF, 16'hFFFF, 32'd5000);
    // tick purges the burst
    send_req(OP_TICK, sensor_t'(2), 32'hFFFF_FFFF, 16'hFFFF, 32'd5200);
    // triple across the 32-bit wrap
    send_req(OP_ARRIVE, sensor_t'(0), 32'hFFFF_FFF0, 16'hAAAA, 32'hFFFF_FFF0);
    send_req(OP_ARRIVE, sensor_t'(1), 32'h0000_0010, 16'h5555, 32'h0000_0005);
    send_req(OP_ARRIVE, sensor_t'(2), 32'hFFFF_FFFF, 16'h00FF, 32'h0000_0010);
    // most negative difference never matches; its age is kept too
    send_req(OP_ARRIVE, sensor_t'(0), 32'h0000_0000, 16'h0001, 32'h0000_0000);
    send_req(OP_ARRIVE, sensor_t'(1), 32'h8000_0000, 16'h0002, 32'h0000_0000);
    send_req(OP_ARRIVE, sensor_t'(2), 32'h0000_0000, 16'h0003, 32'h0000_0000);
    // two triples possible: the first goes now, the second on a later arrival
    send_req(OP_ARRIVE, sensor_t'(0), 32'd20, 16'h0004, 32'h0000_0000);
    send_req(OP_ARRIVE, sensor_t'(2), 32'd20, 16'h0005, 32'h0000_0000);
    send_req(OP_ARRIVE, sensor_t'(1), 32'd10, 16'h0006, 32'h0000_0000);
    send_req(OP_ARRIVE, sensor_t'(1), 32'd15, 16'h0007, 32'h0000_0000);
    send_req(OP_TICK, sensor_t'(0), 32'h0000_0000, 16'h0000, 32'h8000_0000);
  endtask

  // random traffic: mostly frame sets around clock_ms, the rest noise
  task automatic run_segment(input int unsigned n_req);
    int unsigned        first;
    int unsigned        pick;
    int unsigned        jit_max;
    int unsigned        burst;
    int unsigned        a;
    sensor_t            member [SENSOR_COUNT];
    sensor_t            swap_s;
    logic [STAMP_W-1:0] st;
    first   = requests_sent;
    jit_max = cur_window + cur_window / 2 + 3;
    while (requests_sent - first < n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // one capture per sensor in random order, now and then one missing
        member[0] = sensor_t'(0);
        member[1] = sensor_t'(1);
        member[2] = sensor_t'(2);
        for (int i = SENSOR_COUNT - 1; i > 0; i--) begin
          a         = $urandom_range(0, i);
          swap_s    = member[i];
          member[i] = member[a];
          member[a] = swap_s;
        end
        for (int m = 0; m < SENSOR_COUNT; m++) begin
          if (m == SENSOR_COUNT - 1 && $urandom_range(0, 9) == 0) continue;
          if ($urandom_range(0, 1)) st = clock_ms + $urandom_range(0, jit_max);
          else st = clock_ms - $urandom_range(0, jit_max);
          send_req(OP_ARRIVE, member[m], st, TAG_W'($urandom_range(0, 16'hFFFF)),
                   clock_ms + $urandom_range(0, 8));
        end
        clock_ms = clock_ms + $urandom_range(1, 2 * cur_window + 40);
      end else if (pick < 80) begin
        send_req(OP_TICK, sensor_t'($urandom_range(0, 3)), $urandom,
                 TAG_W'($urandom_range(0, 16'hFFFF)),
                 clock_ms + $urandom_range(0, cur_age + cur_age / 2 + 5));
      end else if (pick < 85) begin
        // burst on one sensor to force overflow drops
        a     = $urandom_range(0, SENSOR_COUNT - 1);
        burst = $urandom_range(DEPTH + 1, DEPTH + 3);
        for (int i = 0; i < burst; i++) begin
          send_req(OP_ARRIVE, sensor_t'(a), clock_ms + STAMP_W'(i),
                   TAG_W'($urandom_range(0, 16'hFFFF)), clock_ms);
        end
      end else if (pick < 95) begin
        send_req(OP_ARRIVE, sensor_t'($urandom_range(0, 3)), $urandom,
                 TAG_W'($urandom_range(0, 16'hFFFF)),
                 $urandom_range(0, 1) ? $urandom : clock_ms);
      end else begin
        send_req(OP_ARRIVE, sensor_t'(3), clock_ms, TAG_W'($urandom_range(0, 16'hFFFF)),
                 clock_ms);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    send_idle_pct = 22;
    recv_idle_pct = 85;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    directed_checks();
    wait_drained();

    // sender idles a little, receiver a lot
    clock_ms = 32'd100000;
    set_limits(MATCH_WINDOW_RST, MAX_AGE_RST);
    run_segment(60);
    hold_req = 1'b1;
    run_segment(65);
    wait_drained();
    set_limits(16'd0, 16'd0);
    run_segment(125);
    wait_drained();

    // sender idles a lot, receiver a little; stamps cross the wrap
    send_idle_pct = 85;
    recv_idle_pct = 22;
    clock_ms      = 32'hFFFF_F000;
    set_limits(16'hFFFF, 16'hFFFF);
    run_segment(125);
    wait_drained();
    set_limits(CFG_W'($urandom_range(10, 300)), CFG_W'($urandom_range(30, 500)));
    run_segment(60);
    wait_drained();
    run_segment(65);
    wait_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(16'd20, 16'hFFFF);
    run_segment(125);
    wait_drained();
    set_limits(16'hFFFF, 16'd0);
    run_segment(125);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Summary: %0d requests over %0d window/age settings, wrap and purge corners",
             requests_sent, settings_used);
    $display("Summary: %0d results checked, %0d triples, %0d overflow drops, %0d bad",
             result_count, match_count, drop_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending != 0) $display("%0d predicted results never arrived", pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
